>>> design/m61dpa_pkg.sv
// Shared constants and types for the Mersenne-prime dot product accumulator.
`default_nettype none

package m61dpa_pkg;

  // Width of every operand and result port
  localparam int FIELD_W = 61;

  // Term selection held in the mode register
  typedef enum logic [1:0] {
    TERM_PRODUCT = 2'd0,
    TERM_SUM     = 2'd1,
    TERM_FIRST   = 2'd2,
    TERM_NONE    = 2'd3
  } term_mode_e;

endpackage

`default_nettype wire

>>> design/m61dpa_front.sv
// Front end: input acceptance and reduction of both operands modulo the prime.
`default_nettype none

module m61dpa_front import m61dpa_pkg::*; #(
  parameter int PRIME_BITS = 61
) (
  input  wire logic [FIELD_W-1:0]      first_operand_i,
  input  wire logic [FIELD_W-1:0]      second_operand_i,
  input  wire logic                    last_i,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic                    push_ready_i,
  output logic                         push_valid_o,
  output logic [2*PRIME_BITS:0]        push_data_o
);

  localparam int P    = PRIME_BITS;
  localparam int NCH  = (FIELD_W + PRIME_BITS - 1) / PRIME_BITS;
  localparam int PADW = NCH * PRIME_BITS;
  localparam int SUMW = PRIME_BITS + $clog2(NCH) + 1;
  localparam logic [P-1:0] PMASK = '1;

  logic [P-1:0] a_red;
  logic [P-1:0] b_red;

  // Add the P-wide chunks (2^P is 1 modulo p), fold twice, map p onto zero
  function automatic logic [P-1:0] reduce_field(input logic [FIELD_W-1:0] x);
    logic [PADW-1:0] pad;
    logic [SUMW-1:0] acc;
    logic [SUMW-1:0] f1;
    logic [P-1:0]    f2;
    pad = PADW'(x);
    acc = '0;
    for (int k = 0; k < NCH; k++) begin
      acc = acc + SUMW'(pad[k*P +: P]);
    end
    f1 = SUMW'(acc[P-1:0]) + (acc >> P);
    f2 = f1[P-1:0] + P'(f1 >> P);
    return (f2 == PMASK) ? '0 : f2;
  endfunction

  always_comb begin
    a_red = reduce_field(first_operand_i);
    b_red = reduce_field(second_operand_i);
  end

  assign in_stall_o   = !push_ready_i;
  assign push_valid_o = in_valid_i;
  assign push_data_o  = {last_i, a_red, b_red};

endmodule

`default_nettype wire

>>> design/m61dpa_queue.sv
// Two-entry queue between the front end and the arithmetic back end.
`default_nettype none

module m61dpa_queue #(
  parameter int WIDTH = 123
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic [WIDTH-1:0]      pop_data_o
);

  logic [WIDTH-1:0] entry_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = entry_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

>>> design/m61dpa_back.sv
// Back end: term pipeline (partial products, product, reduction) and accumulator.
`default_nettype none

module m61dpa_back import m61dpa_pkg::*; #(
  parameter int PRIME_BITS = 61
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire term_mode_e            term_mode_i,
  input  wire logic                  q_valid_i,
  output logic                       q_ready_o,
  input  wire logic [2*PRIME_BITS:0] q_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [PRIME_BITS-1:0]      dot_o
);

  localparam int P  = PRIME_BITS;
  localparam int H  = (PRIME_BITS + 1) / 2;
  localparam int LW = PRIME_BITS - H;
  localparam int PW = 2 * PRIME_BITS;
  localparam logic [P-1:0] PMASK = '1;
  localparam logic [P:0]   PMOD  = {1'b0, PMASK};

  // Queue head fields
  logic          in_last;
  logic [P-1:0]  in_a, in_b;
  logic [H-1:0]  a0, b0;
  logic [LW-1:0] a1, b1;

  // Stage registers
  logic              m1_v_q, m2_v_q, m3_v_q, out_v_q;
  logic              m1_last_q, m2_last_q, m3_last_q;
  logic [2*H-1:0]    m1_p00_q;
  logic [P-1:0]      m1_p01_q, m1_p10_q;
  logic [2*LW-1:0]   m1_p11_q;
  logic [P-1:0]      m1_alt_q, m2_alt_q;
  logic [PW-1:0]     m2_prod_q;
  logic [P-1:0]      m3_term_q;
  logic [P-1:0]      total_q, total_d;
  logic [P-1:0]      dot_q;

  // Combinational values
  logic [P:0]        sum_ab, sum_ab_red;
  logic [P-1:0]      alt_d;
  logic [PW-1:0]     prod_d;
  logic [P:0]        prod_fold;
  logic [P-1:0]      prod_red, term_d;
  logic [P:0]        acc_sum, acc_red;
  logic              out_free, acc_fire, m3_ready, m2_ready, m1_ready, pop;

  assign in_last = q_data_i[2*P];
  assign in_a    = q_data_i[2*P-1:P];
  assign in_b    = q_data_i[P-1:0];
  assign a0      = in_a[H-1:0];
  assign a1      = in_a[P-1:H];
  assign b0      = in_b[H-1:0];
  assign b1      = in_b[P-1:H];

  // Flow control: a stage advances when its successor is empty or advancing
  assign out_free  = !out_v_q || !out_stall_i;
  assign acc_fire  = m3_v_q && (!m3_last_q || out_free);
  assign m3_ready  = !m3_v_q || acc_fire;
  assign m2_ready  = !m2_v_q || m3_ready;
  assign m1_ready  = !m1_v_q || m2_ready;
  assign pop       = q_valid_i && m1_ready;
  assign q_ready_o = m1_ready;

  // Terms other than the product
  always_comb begin
    sum_ab     = {1'b0, in_a} + {1'b0, in_b};
    sum_ab_red = (sum_ab >= PMOD) ? (sum_ab - PMOD) : sum_ab;
    unique case (term_mode_i)
      TERM_PRODUCT: alt_d = '0;
      TERM_SUM:     alt_d = sum_ab_red[P-1:0];
      TERM_FIRST:   alt_d = in_a;
      TERM_NONE:    alt_d = '0;
      default:      alt_d = '0;
    endcase
  end

  // Combine partial products, then fold the double-width product
  always_comb begin
    prod_d = PW'(m1_p00_q)
           + ((PW'(m1_p01_q) + PW'(m1_p10_q)) << H)
           + (PW'(m1_p11_q) << (2 * H));
    prod_fold = {1'b0, m2_prod_q[P-1:0]} + {1'b0, m2_prod_q[PW-1:P]};
    prod_red  = prod_fold[P-1:0] + P'(prod_fold[P]);
    if (prod_red == PMASK) begin
      prod_red = '0;
    end
    term_d = (term_mode_i == TERM_PRODUCT) ? prod_red : m2_alt_q;
  end

  // Modular add in the feedback loop
  always_comb begin
    acc_sum = {1'b0, total_q} + {1'b0, m3_term_q};
    acc_red = (acc_sum >= PMOD) ? (acc_sum - PMOD) : acc_sum;
    total_d = m3_last_q ? '0 : acc_red[P-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q  <= 1'b0;
      m2_v_q  <= 1'b0;
      m3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      total_q <= '0;
    end else begin
      if (m1_ready) begin
        m1_v_q <= pop;
      end
      if (m2_ready) begin
        m2_v_q <= m1_v_q;
      end
      if (m3_ready) begin
        m3_v_q <= m2_v_q;
      end
      if (acc_fire) begin
        total_q <= total_d;
      end
      if (acc_fire && m3_last_q) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      m1_last_q <= in_last;
      m1_p00_q  <= (2*H)'(a0) * (2*H)'(b0);
      m1_p01_q  <= P'(a0) * P'(b1);
      m1_p10_q  <= P'(a1) * P'(b0);
      m1_p11_q  <= (2*LW)'(a1) * (2*LW)'(b1);
      m1_alt_q  <= alt_d;
    end
    if (m2_ready && m1_v_q) begin
      m2_last_q <= m1_last_q;
      m2_prod_q <= prod_d;
      m2_alt_q  <= m1_alt_q;
    end
    if (m3_ready && m2_v_q) begin
      m3_last_q <= m2_last_q;
      m3_term_q <= term_d;
    end
    if (acc_fire && m3_last_q) begin
      dot_q <= acc_red[P-1:0];
    end
  end

  assign out_valid_o = out_v_q;
  assign dot_o       = dot_q;

endmodule

`default_nettype wire

>>> design/mersenne61_dot_product_accumulate.sv
// Top level of the dot product accumulator modulo the Mersenne prime 2^PRIME_BITS-1.
//
// Usage:
//   Input channel: first_operand_i, second_operand_i and last_i transfer when
//   in_valid_i is high and in_stall_o is low. Operands of any bit pattern are
//   reduced modulo p on entry. last_i closes a vector.
//   Output channel: dot_result_o transfers when out_valid_o is high and
//   out_stall_i is low. One result per vector, given on its last item, after
//   which the running total restarts from zero.
//   Configuration: cfg_we_i writes cfg_wdata_i into the term mode register
//   (product, sum, first operand only, or zero term). Write it only while idle.
// Throughput: one item per cycle while no last item waits on a stalled result,
//   set by the modular add of the accumulator; the multiplier is split into
//   four partial products over three pipeline stages ahead of it.
// Path: a last item passes the queue, partial products, product combine, fold
//   and accumulate registers before out_valid_o rises.
// Reset: asynchronous, clears the queue, pipeline valids, the running total
//   and the mode register (product mode).
// Stall: while out_stall_i holds a result, items without last keep flowing;
//   a last item waits in the accumulate stage, the pipeline and the two-entry
//   queue fill, then in_stall_o rises.
`default_nettype none

module mersenne61_dot_product_accumulate import m61dpa_pkg::*; #(
  parameter int PRIME_BITS = 61
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_wdata_i,
  input  wire logic [FIELD_W-1:0] first_operand_i,
  input  wire logic [FIELD_W-1:0] second_operand_i,
  input  wire logic               last_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  output logic [FIELD_W-1:0]      dot_result_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i
);

  localparam int QW = 2 * PRIME_BITS + 1;

  term_mode_e              term_mode_q;
  logic                    push_valid, push_ready;
  logic [QW-1:0]           push_data;
  logic                    pop_valid, pop_ready;
  logic [QW-1:0]           pop_data;
  logic [PRIME_BITS-1:0]   dot;

  // Mode register, loaded from cfg_wdata_i while cfg_we_i is high
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_mode_q <= TERM_PRODUCT;
    end else if (cfg_we_i) begin
      term_mode_q <= term_mode_e'(cfg_wdata_i);
    end
  end

  // Accept and reduce operands
  m61dpa_front #(
    .PRIME_BITS (PRIME_BITS)
  ) u_front (
    .first_operand_i  (first_operand_i),
    .second_operand_i (second_operand_i),
    .last_i           (last_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .push_ready_i     (push_ready),
    .push_valid_o     (push_valid),
    .push_data_o      (push_data)
  );

  // Decouple front and back so each can stall on its own
  m61dpa_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Form the term, accumulate, hold the result for transfer
  m61dpa_back #(
    .PRIME_BITS (PRIME_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .term_mode_i (term_mode_q),
    .q_valid_i   (pop_valid),
    .q_ready_o   (pop_ready),
    .q_data_i    (pop_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .dot_o       (dot)
  );

  // Zero-extend to the port width
  assign dot_result_o = FIELD_W'(dot);

endmodule

`default_nettype wire

>>> design/m61dpa_checker.sv
// Port-level checks for the dot product accumulator, bound to the top level.
`default_nettype none

module m61dpa_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic [60:0] dot_result_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i
);

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(dot_result_o))
    else $error("result changed while stalled");

  // A result is always fully reduced, never the all-ones residue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> dot_result_o != 61'h1FFF_FFFF_FFFF_FFFF)
    else $error("result not reduced");

  // No result can appear in the cycle after reset
  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result offered straight after reset");

endmodule

bind mersenne61_dot_product_accumulate m61dpa_checker u_checker (.*);

`default_nettype wire

>>> dv/tb_mersenne61_dot_product_accumulate.sv
// Self-checking testbench for the dot product accumulator modulo 2^61-1.
module tb_mersenne61_dot_product_accumulate;
  import m61dpa_pkg::*;

  // All ones at operand width: the prime itself, which the block takes as zero
  localparam logic [FIELD_W-1:0] PRIME         = {FIELD_W{1'b1}};
  localparam logic [FIELD_W-1:0] BIT60         = 61'h1000_0000_0000_0000;
  localparam int                 NUM_DIRECTED  = 23;
  localparam int                 NUM_PHASES    = 9;
  localparam int                 PHASE_ITEMS   = 190;
  // Give the pipeline a margin before a mode write
  localparam int                 SETTLE_CYCLES = 10;
  localparam int                 HOLD_CYCLES   = 120;
  localparam int                 CYCLE_LIMIT   = 600000;

  // One row of the directed table; typed_dot is used only where typed is set
  typedef struct {
    term_mode_e         mode;
    logic [FIELD_W-1:0] a;
    logic [FIELD_W-1:0] b;
    logic               last;
    logic               typed;
    logic [FIELD_W-1:0] typed_dot;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [1:0]         cfg_wdata_i;
  logic [FIELD_W-1:0] first_operand_i;
  logic [FIELD_W-1:0] second_operand_i;
  logic               last_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [FIELD_W-1:0] dot_result_o;
  logic               out_valid_o;
  logic               out_stall_i;

  // Predictor state: running total and mode register as the block should hold them
  logic [FIELD_W-1:0] pred_total = '0;
  term_mode_e         pred_mode  = TERM_PRODUCT;
  // Totals still owed by the block, oldest first
  logic [FIELD_W-1:0] pending_dots[$];
  logic [FIELD_W-1:0] dot_want;

  int  mismatches    = 0;
  int  cycle_count   = 0;
  // Idling controls for the sender and the receiver
  bit  sender_quiet  = 1'b0;
  bit  sink_quiet    = 1'b0;
  bit  long_hold_req = 1'b0;

  mersenne61_dot_product_accumulate DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .first_operand_i  (first_operand_i),
    .second_operand_i (second_operand_i),
    .last_i           (last_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .dot_result_o     (dot_result_o),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i)
  );

  // 12-unit clock period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Full reduction modulo p: fold the bits above the field width back onto the
  // low bits until nothing is left above, then map p itself to zero.
  function automatic logic [FIELD_W-1:0] mod_p_fold(input logic [127:0] x);
    logic [127:0] v;
    v = x;
    while ((v >> FIELD_W) != 0)
      v = (v & 128'(PRIME)) + (v >> FIELD_W);
    if (v[FIELD_W-1:0] == PRIME)
      v = '0;
    return v[FIELD_W-1:0];
  endfunction

  // Term that one operand pair adds to the total under the given mode
  function automatic logic [FIELD_W-1:0] term_for(input term_mode_e mode,
                                                  input logic [FIELD_W-1:0] a_raw,
                                                  input logic [FIELD_W-1:0] b_raw);
    logic [FIELD_W-1:0] a;
    logic [FIELD_W-1:0] b;
    a = mod_p_fold(128'(a_raw));
    b = mod_p_fold(128'(b_raw));
    case (mode)
      TERM_PRODUCT: return mod_p_fold(128'(a) * 128'(b));
      TERM_SUM:     return mod_p_fold(128'(a) + 128'(b));
      TERM_FIRST:   return a;
      default:      return '0;
    endcase
  endfunction

  // Operand drawn with a bias towards zero, p, p-1, small values, values just
  // below p and single set bits; the rest is full-width noise.
  function automatic logic [FIELD_W-1:0] pick_operand();
    logic [63:0]        raw;
    logic [FIELD_W-1:0] v;
    raw = {$urandom, $urandom};
    v   = '0;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = PRIME;
      2:       v = PRIME - 1'b1;
      3:       v[3:0] = 4'($urandom_range(0, 15));
      4: begin
        v[3:0] = 4'($urandom_range(0, 15));
        v = PRIME - 1'b1 - v;
      end
      5:       v[$urandom_range(0, FIELD_W-1)] = 1'b1;
      default: v = raw[FIELD_W-1:0];
    endcase
    return v;
  endfunction

  // Sender gap: mostly none, some short, a few long
  function automatic int idle_gap();
    int r;
    if (sender_quiet)
      return 0;
    r = $urandom_range(0, 19);
    if (r < 12)
      return 0;
    if (r < 18)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Advance the predictor by one accepted transfer; queue the total on a last
  // item, the typed-in value where the table gives one.
  task automatic record_transfer(input logic [FIELD_W-1:0] a,
                                 input logic [FIELD_W-1:0] b,
                                 input logic last,
                                 input logic typed,
                                 input logic [FIELD_W-1:0] typed_dot);
    pred_total = mod_p_fold(128'(pred_total) + 128'(term_for(pred_mode, a, b)));
    if (last) begin
      pending_dots.push_back(typed ? typed_dot : pred_total);
      pred_total = '0;
    end
  endtask

  // Offer one item and hold it until the block takes it
  task automatic send_operands(input logic [FIELD_W-1:0] a,
                               input logic [FIELD_W-1:0] b,
                               input logic last,
                               input logic typed,
                               input logic [FIELD_W-1:0] typed_dot);
    in_valid_i       <= 1'b1;
    first_operand_i  <= a;
    second_operand_i <= b;
    last_i           <= last;
    @(posedge clk_i);
    while (in_stall_o)
      @(posedge clk_i);
    record_transfer(a, b, last, typed, typed_dot);
  endtask

  // Drop valid for an idle span of n, with noise on the payload that must be ignored
  task automatic idle_sender(input int n);
    in_valid_i       <= 1'b0;
    first_operand_i  <= pick_operand();
    second_operand_i <= pick_operand();
    last_i           <= 1'($urandom_range(0, 1));
    repeat (n) @(posedge clk_i);
  endtask

  // Pause the sender until every owed total has arrived, then let the
  // pipeline empty of items that owe nothing.
  task automatic drain_results();
    idle_sender(1);
    while (pending_dots.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Single-cycle write of the mode register; the block must be idle
  task automatic write_mode(input term_mode_e mode);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    pred_mode    = mode;
  endtask

  // Receiver: stall pattern of random spans, a stretch with no stall while
  // sink_quiet is set, and one long hold-off counted here on request.
  initial begin : sink_stall
    logic hold;
    int   span;
    int   r;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = 1'b1;
        span = HOLD_CYCLES;
      end else if (sink_quiet) begin
        hold = 1'b0;
        span = $urandom_range(1, 8);
      end else begin
        r = $urandom_range(0, 19);
        if (r < 12) begin
          hold = 1'b0;
          span = $urandom_range(1, 6);
        end else if (r < 18) begin
          hold = 1'b1;
          span = $urandom_range(1, 3);
        end else begin
          hold = 1'b1;
          span = $urandom_range(10, 40);
        end
      end
      out_stall_i <= hold;
      repeat (span) @(posedge clk_i);
    end
  end

  // Compare every result transfer with the oldest owed total
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_dots.size() == 0) begin
        $error("dot_result: expected none, actual %h", dot_result_o);
        mismatches++;
      end else begin
        dot_want = pending_dots.pop_front();
        if (dot_result_o !== dot_want) begin
          $error("dot_result: expected %h, actual %h", dot_want, dot_result_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run if the block hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_mersenne61_dot_product_accumulate NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t  rows [NUM_DIRECTED];
    term_mode_e phase_mode;
    logic       last;
    int         gap;
    int         last_odds;

    // Directed table. Rows walk the modes in order; a change of mode drains the
    // block and writes the register. The first rows rely on the reset mode.
    rows = '{
      // product: zeros, ones, (-1)*(-1), p taken as zero, 2^60*2 wraps to one
      '{TERM_PRODUCT, '0,           '0,             1'b1, 1'b1, '0},
      '{TERM_PRODUCT, 61'd1,        61'd1,          1'b1, 1'b1, 61'd1},
      '{TERM_PRODUCT, PRIME - 1'b1, PRIME - 1'b1,   1'b1, 1'b1, 61'd1},
      '{TERM_PRODUCT, PRIME,        61'd5,          1'b1, 1'b1, '0},
      '{TERM_PRODUCT, BIT60,        61'd2,          1'b1, 1'b1, 61'd1},
      // two-item vector: -2 + 3
      '{TERM_PRODUCT, PRIME - 1'b1, 61'd2,          1'b0, 1'b0, '0},
      '{TERM_PRODUCT, 61'd3,        61'd1,          1'b1, 1'b1, 61'd1},
      '{TERM_PRODUCT, 61'h0123_4567_89ab_cdef, 61'h1fed_cba9_8765_4321,
        1'b0, 1'b0, '0},
      '{TERM_PRODUCT, 61'h1555_5555_5555_5555, 61'h0aaa_aaaa_aaaa_aaaa,
        1'b1, 1'b0, '0},
      // sum: wrap to zero, p plus p, (-1)+(-1)
      '{TERM_SUM,     PRIME - 1'b1, 61'd1,          1'b1, 1'b1, '0},
      '{TERM_SUM,     PRIME,        PRIME,          1'b1, 1'b1, '0},
      '{TERM_SUM,     PRIME - 1'b1, PRIME - 1'b1,   1'b1, 1'b1, PRIME - 61'd2},
      '{TERM_SUM,     BIT60,        BIT60,          1'b0, 1'b0, '0},
      '{TERM_SUM,     61'd5,        61'd7,          1'b1, 1'b0, '0},
      // first operand only: second operand ignored, p taken as zero
      '{TERM_FIRST,   PRIME - 1'b1, PRIME,          1'b0, 1'b0, '0},
      '{TERM_FIRST,   61'd1,        PRIME - 1'b1,   1'b1, 1'b1, '0},
      '{TERM_FIRST,   61'd42,       PRIME,          1'b1, 1'b1, 61'd42},
      '{TERM_FIRST,   PRIME,        61'd1,          1'b1, 1'b1, '0},
      // unused mode: zero term, last still closes the vector
      '{TERM_NONE,    PRIME - 1'b1, PRIME - 1'b1,   1'b0, 1'b0, '0},
      '{TERM_NONE,    61'd7,        61'd9,          1'b1, 1'b1, '0},
      '{TERM_NONE,    '0,           '0,             1'b1, 1'b1, '0},
      // back to product: -1 + 1
      '{TERM_PRODUCT, PRIME - 1'b1, 61'd1,          1'b0, 1'b0, '0},
      '{TERM_PRODUCT, 61'd1,        61'd1,          1'b1, 1'b1, '0}
    };

    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = TERM_PRODUCT;
    first_operand_i  = '0;
    second_operand_i = '0;
    last_i           = 1'b0;
    in_valid_i       = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].mode != pred_mode) begin
        drain_results();
        write_mode(rows[i].mode);
      end
      send_operands(rows[i].a, rows[i].b, rows[i].last, rows[i].typed,
                    rows[i].typed_dot);
      gap = idle_gap();
      if (gap > 0)
        idle_sender(gap);
    end

    // Random phases. The first four visit every mode; each phase picks its own
    // odds of a last item so that both single-item and long vectors occur.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      case (ph)
        0:       phase_mode = TERM_SUM;
        1:       phase_mode = TERM_PRODUCT;
        2:       phase_mode = TERM_NONE;
        3:       phase_mode = TERM_FIRST;
        default: phase_mode = term_mode_e'($urandom_range(0, 3));
      endcase
      write_mode(phase_mode);
      sender_quiet = 1'b0;
      sink_quiet   = 1'b0;
      last_odds    = $urandom_range(1, 12);
      if (ph == 1) begin
        // Hold the receiver off while the sender streams back to back, so the
        // accumulate stage, pipeline and queue fill and the input stalls
        sender_quiet  = 1'b1;
        long_hold_req = 1'b1;
        last_odds     = 4;
      end else if (ph == 4) begin
        sender_quiet = 1'b1;
        sink_quiet   = 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Pause the sender once mid-vector until every owed total has arrived
        if (ph == 5 && n == PHASE_ITEMS / 2)
          drain_results();
        last = ($urandom_range(1, last_odds) == 1);
        send_operands(pick_operand(), pick_operand(), last, 1'b0, '0);
        gap = idle_gap();
        if (gap > 0)
          idle_sender(gap);
      end
    end

    // Close the open vector, then wait out the last totals
    send_operands(pick_operand(), pick_operand(), 1'b1, 1'b0, '0);
    drain_results();

    if (mismatches == 0)
      $display("tb_mersenne61_dot_product_accumulate OK");
    else
      $display("tb_mersenne61_dot_product_accumulate NOT OK");
    $finish;
  end

endmodule
